// ----- hw/rtl/nprx_pkg.sv -----
// Shared types and constants for the nibble-pair frame receiver.
package nprx_pkg;

	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_CODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_CODE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_REPLY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OK_REPLY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_REPLY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOO_BIG_REPLY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT    = 3'd6;

	localparam logic [4:0] SIZE_LIMIT_RST = 5'd16;

	// receive phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// which reply a queued word carries
	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_OK      = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;
	localparam logic [1:0] KIND_TOO_BIG = 2'd3;

	localparam logic [1:0] STATUS_COMPLETE = 2'd0;
	localparam logic [1:0] STATUS_BAD_TAG  = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;

	typedef struct packed {
		logic [3:0] request_code;
		logic [3:0] data_code;
		logic [7:0] clear_reply;
		logic [7:0] ok_reply;
		logic [7:0] bad_reply;
		logic [7:0] too_big_reply;
		logic [4:0] size_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [3:0] data_index;
		logic       frame_done;
		logic [3:0] frame_length;
		logic [1:0] frame_status;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

endpackage

// ----- hw/rtl/nibble_pair_frame_receiver_top.sv -----
// Top level of the nibble-pair frame receiver.
// Takes one received byte per cycle on the slave stream and emits at most one reply word per
// byte on the master stream; a reply is registered in the queue and then in the back end output
// register. Sustained rate is one byte per cycle, set by the combinational classify step in the
// front end; s_axis_tready drops only while the FIFO_DEPTH-entry queue is full because the sink
// is stalling. Registers are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce; unknown indexes are ignored.
module nibble_pair_frame_receiver_top
	import nprx_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] reply_byte, [15:8] data_byte, [19:16] data_index, [23:20] frame_length,
	// [25:24] frame_status, [31:26] zero
	output logic [31:0]           m_axis_tdata,
	output logic                  m_axis_tuser,  // [0] data_valid
	output logic                  m_axis_tlast   // frame_done
);

	cfg_t     cfg_q;
	logic     in_fire;
	logic     push;
	entry_t   push_entry;
	logic     pop;
	entry_t   head;
	fifo_st_t fifo_st;
	logic [7:0] reply_byte;
	entry_t   out_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{request_code: 4'd0, data_code: 4'd0, clear_reply: 8'd0,
				ok_reply: 8'd0, bad_reply: 8'd0, too_big_reply: 8'd0,
				size_limit: SIZE_LIMIT_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REQUEST_CODE:  cfg_q.request_code  <= cfg_data[3:0];
				REG_DATA_CODE:     cfg_q.data_code     <= cfg_data[3:0];
				REG_CLEAR_REPLY:   cfg_q.clear_reply   <= cfg_data;
				REG_OK_REPLY:      cfg_q.ok_reply      <= cfg_data;
				REG_BAD_REPLY:     cfg_q.bad_reply     <= cfg_data;
				REG_TOO_BIG_REPLY: cfg_q.too_big_reply <= cfg_data;
				REG_SIZE_LIMIT:    cfg_q.size_limit    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !fifo_st.full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	nprx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_fire    (in_fire),
		.rx_byte    (s_axis_tdata),
		.push       (push),
		.push_entry (push_entry)
	);

	nprx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (fifo_st)
	);

	nprx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.fifo_st    (fifo_st),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.reply_byte (reply_byte),
		.out_entry  (out_entry)
	);

	assign m_axis_tdata = {6'd0, out_entry.frame_status, out_entry.frame_length,
		out_entry.data_index, out_entry.data_byte, reply_byte};
	assign m_axis_tuser = out_entry.data_valid;
	assign m_axis_tlast = out_entry.frame_done;

	// a queued word must reach the output register on the next cycle when the slot is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !fifo_st.empty |=> m_axis_tvalid)
		else $error("queued word not moved to output");

	// an error status always closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] != STATUS_COMPLETE |-> m_axis_tlast)
		else $error("error status without frame end");

	// decoded data fields are clear when no data byte is carried
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[19:8] == 12'd0)
		else $error("data fields set without data_valid");

	// frame summary fields are clear on words that do not end the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[25:20] == 6'd0)
		else $error("frame fields set without frame_done");

endmodule

// ----- hw/rtl/nprx_front.sv -----
// Front end: tracks the frame phase and classifies each received byte.
module nprx_front
	import nprx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_fire,
	input  logic [7:0] rx_byte,
	output logic       push,
	output entry_t     push_entry
);

	logic [1:0] phase_q;
	logic [3:0] expected_q;
	logic [3:0] decoded_q;
	logic [7:0] held_q;

	logic [1:0] phase_d;
	logic [3:0] expected_d;
	logic [3:0] decoded_d;
	logic [3:0] hi;
	logic [3:0] size;
	logic [3:0] dec_inc;

	assign hi      = rx_byte[7:4];
	assign size    = rx_byte[3:0];
	assign dec_inc = 4'(decoded_q + 4'd1);

	always_comb begin
		phase_d    = phase_q;
		expected_d = expected_q;
		decoded_d  = decoded_q;
		push       = 1'b0;
		push_entry = '0;
		case (phase_q)
			PH_FIRST: begin
				phase_d = PH_SECOND;
			end
			PH_SECOND: begin
				push = 1'b1;
				if (held_q[7:4] == cfg.data_code && hi == cfg.data_code) begin
					decoded_d             = dec_inc;
					push_entry.kind       = KIND_OK;
					push_entry.data_valid = 1'b1;
					push_entry.data_byte  = {held_q[3:0], rx_byte[3:0]};
					push_entry.data_index = decoded_q;
					if (dec_inc == expected_q) begin
						phase_d                 = PH_IDLE;
						push_entry.frame_done   = 1'b1;
						push_entry.frame_length = dec_inc;
					end else begin
						phase_d = PH_FIRST;
					end
				end else begin
					phase_d                 = PH_IDLE;
					push_entry.kind         = KIND_BAD;
					push_entry.frame_done   = 1'b1;
					push_entry.frame_length = decoded_q;
					push_entry.frame_status = STATUS_BAD_TAG;
				end
			end
			default: begin
				// idle and the unused code both wait for a request
				phase_d = PH_IDLE;
				if (hi == cfg.request_code) begin
					push = 1'b1;
					if ({1'b0, size} < cfg.size_limit) begin
						push_entry.kind = KIND_CLEAR;
						if (size == 4'd0) begin
							push_entry.frame_done = 1'b1;
						end else begin
							expected_d = size;
							decoded_d  = 4'd0;
							phase_d    = PH_FIRST;
						end
					end else begin
						push_entry.kind         = KIND_TOO_BIG;
						push_entry.frame_done   = 1'b1;
						push_entry.frame_status = STATUS_TOO_BIG;
					end
				end
			end
		endcase
		if (!in_fire) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			expected_q <= 4'd0;
			decoded_q  <= 4'd0;
			held_q     <= 8'd0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			expected_q <= expected_d;
			decoded_q  <= decoded_d;
			if (phase_q == PH_FIRST) begin
				held_q <= rx_byte;
			end
		end
	end

endmodule

// ----- hw/rtl/nprx_fifo.sv -----
// Short queue of classified words between front and back.
module nprx_fifo
	import nprx_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  entry_t   push_entry,
	input  logic     pop,
	output entry_t   head,
	output fifo_st_t status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign status.full  = (count_q == (AW+1)'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/nprx_back.sv -----
// Back end: picks the reply byte and holds the result word for the sink.
module nprx_back
	import nprx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  entry_t   head,
	input  fifo_st_t fifo_st,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output logic [7:0] reply_byte,
	output entry_t   out_entry
);

	logic       valid_q;
	logic [7:0] reply_q;
	entry_t     entry_q;
	logic [7:0] reply_d;

	// advance when the output slot is free or is being taken
	assign pop = !fifo_st.empty && (!valid_q || out_ready);

	always_comb begin
		case (head.kind)
			KIND_CLEAR: reply_d = cfg.clear_reply;
			KIND_OK:    reply_d = cfg.ok_reply;
			KIND_BAD:   reply_d = cfg.bad_reply;
			default:    reply_d = cfg.too_big_reply;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			reply_q <= reply_d;
			entry_q <= head;
		end
	end

	assign out_valid  = valid_q;
	assign reply_byte = reply_q;
	assign out_entry  = entry_q;

endmodule

// ----- verif/nibble_pair_frame_receiver_top_tb.sv -----
// Self-checking testbench for the nibble-pair frame receiver top level.
module nibble_pair_frame_receiver_top_tb;
	import nprx_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [3:0] data_index;
		logic       frame_done;
		logic [3:0] frame_length;
		logic [1:0] frame_status;
	} reply_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [31:0]           m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// shadow registers and receive state of the predictor
	cfg_t        regs;
	logic [1:0]  rx_phase;
	logic [3:0]  pairs_wanted;
	logic [3:0]  pairs_decoded;
	logic [7:0]  first_half;

	reply_word_t pending_replies[$];
	reply_word_t want;
	int          fault_count = 0;
	int          burst_left = 0;
	int          random_sent = 0;
	int          sink_mode = 0;
	int          sink_left = 0;

	nibble_pair_frame_receiver_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// work out the reply, if any, to one accepted byte
	task automatic decode_rx_byte(input logic [7:0] b);
		reply_word_t w;
		w = '0;
		case (rx_phase)
			PH_FIRST: begin
				first_half = b;
				rx_phase = PH_SECOND;
			end
			PH_SECOND: begin
				rx_phase = PH_FIRST;
				if (first_half[7:4] == regs.data_code && b[7:4] == regs.data_code) begin
					w.reply_byte = regs.ok_reply;
					w.data_valid = 1'b1;
					w.data_byte = {first_half[3:0], b[3:0]};
					w.data_index = pairs_decoded;
					pairs_decoded = pairs_decoded + 4'd1;
					if (pairs_decoded == pairs_wanted) begin
						rx_phase = PH_IDLE;
						w.frame_done = 1'b1;
						w.frame_length = pairs_decoded;
						w.frame_status = STATUS_COMPLETE;
					end
				end else begin
					rx_phase = PH_IDLE;
					w.reply_byte = regs.bad_reply;
					w.frame_done = 1'b1;
					w.frame_length = pairs_decoded;
					w.frame_status = STATUS_BAD_TAG;
				end
				pending_replies.push_back(w);
			end
			default: begin
				rx_phase = PH_IDLE;
				if (b[7:4] == regs.request_code) begin
					if ({1'b0, b[3:0]} < regs.size_limit) begin
						w.reply_byte = regs.clear_reply;
						if (b[3:0] == 4'd0) begin
							w.frame_done = 1'b1;
						end else begin
							pairs_wanted = b[3:0];
							pairs_decoded = 4'd0;
							rx_phase = PH_FIRST;
						end
					end else begin
						w.reply_byte = regs.too_big_reply;
						w.frame_done = 1'b1;
						w.frame_status = STATUS_TOO_BIG;
					end
					pending_replies.push_back(w);
				end
			end
		endcase
	endtask

	task automatic send_rx_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// the odd long burst gives stretches with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) :
				$urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		decode_rx_byte(b);
	endtask

	// hold the input idle until every reply is out and the pipeline has drained
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_REQUEST_CODE:  regs.request_code = val[3:0];
			REG_DATA_CODE:     regs.data_code = val[3:0];
			REG_CLEAR_REPLY:   regs.clear_reply = val;
			REG_OK_REPLY:      regs.ok_reply = val;
			REG_BAD_REPLY:     regs.bad_reply = val;
			REG_TOO_BIG_REPLY: regs.too_big_reply = val;
			REG_SIZE_LIMIT:    regs.size_limit = val[4:0];
			default: ;
		endcase
	endtask

	// write every register, with junk in the unused upper bits, plus a stray index
	task automatic load_config(input cfg_t c);
		wait_quiet();
		write_reg(REG_REQUEST_CODE, {4'($urandom), c.request_code});
		write_reg(REG_DATA_CODE, {4'($urandom), c.data_code});
		write_reg(REG_CLEAR_REPLY, c.clear_reply);
		write_reg(REG_OK_REPLY, c.ok_reply);
		write_reg(REG_BAD_REPLY, c.bad_reply);
		write_reg(REG_TOO_BIG_REPLY, c.too_big_reply);
		write_reg(REG_SIZE_LIMIT, {3'($urandom), c.size_limit});
		write_reg(REG_UNUSED, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t random_regs();
		cfg_t c;
		c.request_code = 4'($urandom);
		c.data_code = 4'($urandom);
		c.clear_reply = 8'($urandom);
		c.ok_reply = 8'($urandom);
		c.bad_reply = 8'($urandom);
		c.too_big_reply = 8'($urandom);
		case ($urandom_range(0, 5))
			0:       c.size_limit = 5'd0;
			1:       c.size_limit = 5'd16;
			2:       c.size_limit = 5'($urandom_range(17, 31));
			default: c.size_limit = 5'($urandom_range(1, 16));
		endcase
		return c;
	endfunction

	task automatic send_random_frame();
		logic [3:0] size;
		logic [3:0] tag_a;
		logic [3:0] tag_b;
		int         kind;
		// idle noise: upper nibble anything but the request code
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_rx_byte({regs.request_code + 4'($urandom_range(1, 15)), 4'($urandom)});
		case ($urandom_range(0, 9))
			0:       size = 4'd0;
			1:       size = 4'd15;
			2:       size = 4'($urandom);
			default: size = 4'($urandom_range(1, 4));
		endcase
		send_rx_byte({regs.request_code, size});
		random_sent++;
		if (size == 4'd0 || {1'b0, size} >= regs.size_limit)
			return;
		for (int i = 0; i < size; i++) begin
			tag_a = regs.data_code;
			tag_b = regs.data_code;
			kind = $urandom_range(0, 24);
			if (kind == 0 || kind == 2)
				tag_a = regs.data_code + 4'($urandom_range(1, 15));
			if (kind == 1 || kind == 2)
				tag_b = regs.data_code + 4'($urandom_range(1, 15));
			send_rx_byte({tag_a, 4'($urandom)});
			send_rx_byte({tag_b, 4'($urandom)});
			random_sent += 2;
			if (kind <= 2)
				return;
		end
	endtask

	task automatic test_reset_values();
		send_rx_byte(8'h00);  // zero-size frame
		send_rx_byte(8'h12);  // not a request: drop
		send_rx_byte(8'h01);
		send_rx_byte(8'h0A);
		send_rx_byte(8'h05);
	endtask

	task automatic test_good_frames();
		load_config('{request_code: 4'hA, data_code: 4'h5, clear_reply: 8'h11,
			ok_reply: 8'h22, bad_reply: 8'h33, too_big_reply: 8'h44, size_limit: 5'd16});
		send_rx_byte(8'hA2);
		send_rx_byte(8'h5F);
		send_rx_byte(8'h50);
		send_rx_byte(8'h50);
		send_rx_byte(8'h5F);
		send_rx_byte(8'hB0);
		send_rx_byte(8'hA0);
	endtask

	task automatic test_bad_tags();
		// bad tag on the first byte of the second pair
		send_rx_byte(8'hA3);
		send_rx_byte(8'h51);
		send_rx_byte(8'h52);
		send_rx_byte(8'h61);
		send_rx_byte(8'h52);
		// bad tag on the second byte of the first pair
		send_rx_byte(8'hA2);
		send_rx_byte(8'h5C);
		send_rx_byte(8'h4D);
	endtask

	task automatic test_size_limits();
		load_config('{request_code: 4'hA, data_code: 4'h5, clear_reply: 8'h11,
			ok_reply: 8'h22, bad_reply: 8'h33, too_big_reply: 8'h44, size_limit: 5'd0});
		send_rx_byte(8'hA0);
		load_config('{request_code: 4'hA, data_code: 4'h5, clear_reply: 8'h11,
			ok_reply: 8'h22, bad_reply: 8'h33, too_big_reply: 8'h44, size_limit: 5'd31});
		send_rx_byte(8'hAF);
		send_rx_byte(8'h00);
		send_rx_byte(8'h00);
		load_config('{request_code: 4'hA, data_code: 4'h5, clear_reply: 8'h11,
			ok_reply: 8'h22, bad_reply: 8'h33, too_big_reply: 8'h44, size_limit: 5'd4});
		send_rx_byte(8'hA4);
	endtask

	task automatic test_reply_extremes();
		load_config('{request_code: 4'hF, data_code: 4'hF, clear_reply: 8'hFF,
			ok_reply: 8'hFF, bad_reply: 8'hFF, too_big_reply: 8'hFF, size_limit: 5'd16});
		send_rx_byte(8'hFF);
		send_rx_byte(8'hFF);
		send_rx_byte(8'hFF);
		send_rx_byte(8'h0F);
		send_rx_byte(8'hFF);
	endtask

	task automatic test_random_frames();
		int start;
		for (int p = 0; p < 8; p++) begin
			load_config(random_regs());
			start = random_sent;
			while (random_sent - start < 50)
				send_random_frame();
		end
	endtask

	// receiver stalls on a pattern that switches whenever its random hold count runs out
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= $urandom_range(0, 3);
			sink_left <= $urandom_range(20, 120);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
			2:       m_axis_tready <= (sink_left % 5) != 0;
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				$error("reply word 0x%0h with none expected", m_axis_tdata);
				fault_count++;
			end else begin
				want = pending_replies.pop_front();
				check_field("reply_byte", want.reply_byte, m_axis_tdata[7:0]);
				check_field("data_valid", want.data_valid, m_axis_tuser);
				check_field("data_byte", want.data_byte, m_axis_tdata[15:8]);
				check_field("data_index", want.data_index, m_axis_tdata[19:16]);
				check_field("frame_done", want.frame_done, m_axis_tlast);
				check_field("frame_length", want.frame_length, m_axis_tdata[23:20]);
				check_field("frame_status", want.frame_status, m_axis_tdata[25:24]);
				check_field("tdata padding", 0, m_axis_tdata[31:26]);
			end
		end
	end

	initial begin
		#3000000;
		$display("[nibble_pair_frame_receiver_top] ERROR");
		$finish;
	end

	initial begin
		regs = '0;
		regs.size_limit = SIZE_LIMIT_RST;
		rx_phase = PH_IDLE;
		pairs_wanted = 4'd0;
		pairs_decoded = 4'd0;
		first_half = 8'd0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_good_frames();
		test_bad_tags();
		test_size_limits();
		test_reply_extremes();
		test_random_frames();

		wait_quiet();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("[nibble_pair_frame_receiver_top] OK");
		else
			$display("[nibble_pair_frame_receiver_top] ERROR");
		$finish;
	end

endmodule
